// ===== design/kst_pkg.sv =====
// ----------------------------------------------------------------------------
// kst_pkg - shared types and constants of the key state hotkey tracker
// Item and result layouts, action and combo codes, controller command and
// status groups.
// ----------------------------------------------------------------------------
package kst_pkg;

  // action codes
  localparam logic [2:0] ACT_KEY_EVENT  = 3'd0;
  localparam logic [2:0] ACT_FRAME_TICK = 3'd1;
  localparam logic [2:0] ACT_BIND       = 3'd2;
  localparam logic [2:0] ACT_QUERY_KEY  = 3'd3;
  localparam logic [2:0] ACT_QUERY_HOT  = 3'd4;

  // combo codes
  localparam logic [2:0] COMBO_NONE       = 3'd0;
  localparam logic [2:0] COMBO_ALT        = 3'd1;
  localparam logic [2:0] COMBO_ALT_SHIFT  = 3'd2;
  localparam logic [2:0] COMBO_CTRL       = 3'd3;
  localparam logic [2:0] COMBO_CTRL_SHIFT = 3'd4;
  localparam logic [2:0] COMBO_SHIFT      = 3'd5;

  // modifier bits as stored per key
  localparam logic [2:0] MOD_CONTROL = 3'b001;
  localparam logic [2:0] MOD_SHIFT   = 3'b010;
  localparam logic [2:0] MOD_ALT     = 3'b100;

  localparam logic [5:0] AGE_MAX       = 6'd63;
  localparam logic [5:0] REPEAT_RESET  = 6'd30;
  localparam int         ITEM_W        = 27;
  localparam int         IN_TDATA_W    = 32;
  localparam int         OUT_TDATA_W   = 8;

  // input item, last declared field (action) in the lowest bits
  typedef struct packed {
    logic       bind_used;
    logic [2:0] combo;
    logic       slot;
    logic [6:0] function_index;
    logic       alt_held;
    logic       shift_held;
    logic       control_held;
    logic       pressed;
    logic [7:0] key;
    logic [2:0] action;
  } item_t;

  // result item, last declared field (key_down) in the lowest bits
  typedef struct packed {
    logic hotkey_tapped;
    logic hotkey_down;
    logic key_alt;
    logic key_shift;
    logic key_control;
    logic key_repeat;
    logic key_tapped;
    logic key_down;
  } result_t;

  // one hotkey slot
  typedef struct packed {
    logic       used;
    logic [2:0] combo;
    logic [7:0] key;
  } bind_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic rd_item;
    logic rd_bind;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic hot;
  } status_t;

  // modifier set that a combo code asks for
  function automatic logic [2:0] combo_mods(input logic [2:0] combo);
    logic [2:0] m;
    case (combo)
      COMBO_ALT:        m = MOD_ALT;
      COMBO_ALT_SHIFT:  m = MOD_ALT | MOD_SHIFT;
      COMBO_CTRL:       m = MOD_CONTROL;
      COMBO_CTRL_SHIFT: m = MOD_CONTROL | MOD_SHIFT;
      COMBO_SHIFT:      m = MOD_SHIFT;
      default:          m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

// ===== design/key_state_hotkey_tracker.sv =====
// ----------------------------------------------------------------------------
// key_state_hotkey_tracker - key state, frame age and hotkey binding tracker
// Streaming item in, one result transfer out per item, one config register.
// ----------------------------------------------------------------------------
// One item is handled at a time. Key events, frame ticks, binds, key queries
// and unknown actions pass through S_EXEC, where the result is registered on
// finish; a hotkey query passes through S_EXEC and S_HOT and registers its
// result on leaving S_HOT, since the binding memory read must complete
// before the key state memory is read at the two bound keys. Every memory
// read is registered. A result waiting in the output register holds off
// only the completion of the next item, not its acceptance. Frame ages are
// kept as per-key frame stamps against a running frame counter, and each
// tick scrubs one key entry so that an old stamp saturates at 63 before the
// counter can wrap. After reset a clearing pass over max(NUM_KEYS,
// NUM_FUNCTIONS) entries runs with in_tready low; config writes are taken.
module key_state_hotkey_tracker #(
  parameter int NUM_KEYS      = 256,
  parameter int NUM_FUNCTIONS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // action[2:0], key[10:3], pressed[11], control_held[12], shift_held[13],
  // alt_held[14], function_index[21:15], slot[22], combo[25:23],
  // bind_used[26], zero fill[31:27]
  input  logic [31:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // key_down[0], key_tapped[1], key_repeat[2], key_control[3], key_shift[4],
  // key_alt[5], hotkey_down[6], hotkey_tapped[7]
  output logic [7:0]  out_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  logic        cfg_wen,
  input  logic [5:0]  cfg_wdata
);

  kst_pkg::item_t   item;
  kst_pkg::cmd_t    cmd;
  kst_pkg::status_t status;
  kst_pkg::result_t result;

  // unpack the item transfer
  assign item      = kst_pkg::item_t'(in_tdata[kst_pkg::ITEM_W-1:0]);
  assign out_tdata = kst_pkg::OUT_TDATA_W'(result);

  kst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  kst_datapath #(
    .NUM_KEYS      (NUM_KEYS),
    .NUM_FUNCTIONS (NUM_FUNCTIONS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (item),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .status    (status),
    .result    (result)
  );

endmodule

// ===== design/kst_ctrl.sv =====
// ----------------------------------------------------------------------------
// kst_ctrl - sequencer of the key state hotkey tracker
// Runs the clearing pass after reset, takes one item at a time, orders the
// memory reads and owns the result valid flag.
// ----------------------------------------------------------------------------
module kst_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  kst_pkg::status_t status,
  output kst_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_HOT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.rd_item = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status.hot) begin
          cmd.rd_bind = 1'b1;
          state_nxt   = S_HOT;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_HOT: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  // result valid: set on finish, dropped after the transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/kst_datapath.sv =====
// ----------------------------------------------------------------------------
// kst_datapath - storage and evaluation of the key state hotkey tracker
// Key state memory with frame stamps, two binding memories, the repeat
// threshold, the frame counter with its saturation scrubber and the result.
// ----------------------------------------------------------------------------
module kst_datapath #(
  parameter int NUM_KEYS      = 256,
  parameter int NUM_FUNCTIONS = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kst_pkg::item_t    in_item,
  input  logic              cfg_wen,
  input  logic [5:0]        cfg_wdata,
  input  kst_pkg::cmd_t     cmd,
  output kst_pkg::status_t  status,
  output kst_pkg::result_t  result
);

  localparam int KW  = $clog2(NUM_KEYS);
  localparam int FW  = (NUM_FUNCTIONS > 1) ? $clog2(NUM_FUNCTIONS) : 1;
  localparam int TW  = KW + 7;
  localparam int CLR = (NUM_KEYS > NUM_FUNCTIONS) ? NUM_KEYS : NUM_FUNCTIONS;
  localparam int CW  = $clog2(CLR);

  // per key entry: frame stamp of the last event, saturated flag, modifiers
  typedef struct packed {
    logic [TW-1:0] stamp;
    logic          sat;
    logic [2:0]    mods;
    logic          down;
  } kent_t;

  kent_t          key_mem [NUM_KEYS];
  kst_pkg::bind_t bind0_mem [NUM_FUNCTIONS];
  kst_pkg::bind_t bind1_mem [NUM_FUNCTIONS];

  kst_pkg::item_t   item_r;
  kst_pkg::result_t result_r;
  kent_t            rda_r, rdb_r;
  kst_pkg::bind_t   bind0_r, bind1_r;
  logic [5:0]       thr_r;
  logic [TW-1:0]    tick_r, tick_nxt;
  logic [KW-1:0]    scrub_r, scrub_nxt;
  logic [CW-1:0]    clr_r;

  logic             kw_en;
  logic [KW-1:0]    kw_addr;
  kent_t            kw_data;
  logic [KW-1:0]    ra_addr, rb_addr;
  logic             bw_en0, bw_en1;
  logic [FW-1:0]    bw_addr;
  kst_pkg::bind_t   bw_data;
  kst_pkg::result_t res;
  logic [5:0]       age_a, age_b;
  logic             m0_down, m1_down, m0_tap, m1_tap;

  function automatic logic key_ok(input logic [7:0] k);
    return (32'(k) < NUM_KEYS);
  endfunction

  function automatic logic func_ok(input logic [6:0] f);
    return (32'(f) < NUM_FUNCTIONS);
  endfunction

  // saturated frame age from the stamp and the running frame count
  function automatic logic [5:0] age_of(input kent_t e, input logic [TW-1:0] now);
    logic [TW-1:0] diff;
    diff = now - e.stamp;
    if (e.sat || diff >= TW'(kst_pkg::AGE_MAX)) begin
      return kst_pkg::AGE_MAX;
    end
    return diff[5:0];
  endfunction

  assign status.clear_last = (clr_r == CW'(CLR - 1));
  assign status.hot        = (item_r.action == kst_pkg::ACT_QUERY_HOT);
  assign result            = result_r;

  assign age_a = age_of(rda_r, tick_r);
  assign age_b = age_of(rdb_r, tick_r);

  // key state write: clearing pass, key event or scrub of one entry per tick
  always_comb begin
    kw_en   = 1'b0;
    kw_addr = scrub_r;
    kw_data = rda_r;
    if (cmd.clear) begin
      kw_en   = (32'(clr_r) < NUM_KEYS);
      kw_addr = clr_r[KW-1:0];
      kw_data = '0;
    end else if (cmd.finish && item_r.action == kst_pkg::ACT_KEY_EVENT) begin
      kw_en         = key_ok(item_r.key);
      kw_addr       = KW'(item_r.key);
      kw_data.stamp = tick_r;
      kw_data.sat   = 1'b0;
      kw_data.mods  = {item_r.alt_held, item_r.shift_held, item_r.control_held};
      kw_data.down  = item_r.pressed;
    end else if (cmd.finish && item_r.action == kst_pkg::ACT_FRAME_TICK) begin
      kw_en       = 1'b1;
      kw_data.sat = (age_a == kst_pkg::AGE_MAX);
    end
  end

  // binding write: clearing pass or bind item
  always_comb begin
    bw_en0  = 1'b0;
    bw_en1  = 1'b0;
    bw_addr = FW'(item_r.function_index);
    bw_data = '{used: item_r.bind_used, combo: item_r.combo, key: item_r.key};
    if (cmd.clear) begin
      bw_en0  = (32'(clr_r) < NUM_FUNCTIONS);
      bw_en1  = (32'(clr_r) < NUM_FUNCTIONS);
      bw_addr = clr_r[FW-1:0];
      bw_data = '0;
    end else if (cmd.finish && item_r.action == kst_pkg::ACT_BIND &&
                 func_ok(item_r.function_index)) begin
      bw_en0 = !item_r.slot;
      bw_en1 = item_r.slot;
    end
  end

  // read addresses: incoming item (or scrub entry on a tick) first, then the two bound keys
  always_comb begin
    if (cmd.rd_bind) begin
      ra_addr = KW'(bind0_r.key);
    end else if (in_item.action == kst_pkg::ACT_FRAME_TICK) begin
      ra_addr = scrub_r;
    end else begin
      ra_addr = KW'(in_item.key);
    end
    rb_addr = KW'(bind1_r.key);
  end

  // key state memory
  always_ff @(posedge clk) begin
    if (kw_en) begin
      key_mem[kw_addr] <= kw_data;
    end
    if (cmd.rd_item || cmd.rd_bind) begin
      rda_r <= key_mem[ra_addr];
    end
    if (cmd.rd_bind) begin
      rdb_r <= key_mem[rb_addr];
    end
  end

  // binding memories, one per slot
  always_ff @(posedge clk) begin
    if (bw_en0) begin
      bind0_mem[bw_addr] <= bw_data;
    end
    if (bw_en1) begin
      bind1_mem[bw_addr] <= bw_data;
    end
    if (cmd.rd_item) begin
      bind0_r <= bind0_mem[FW'(in_item.function_index)];
      bind1_r <= bind1_mem[FW'(in_item.function_index)];
    end
  end

  // slot matches of a hotkey query
  always_comb begin
    m0_down = bind0_r.used && key_ok(bind0_r.key) && rda_r.down &&
              (rda_r.mods == kst_pkg::combo_mods(bind0_r.combo));
    m1_down = bind1_r.used && key_ok(bind1_r.key) && rdb_r.down &&
              (rdb_r.mods == kst_pkg::combo_mods(bind1_r.combo));
    m0_tap  = m0_down && (age_a == 6'd0);
    m1_tap  = m1_down && (age_b == 6'd0);
  end

  // result of the current item
  always_comb begin
    res = '0;
    case (item_r.action)
      kst_pkg::ACT_QUERY_KEY: begin
        if (key_ok(item_r.key)) begin
          res.key_down    = rda_r.down;
          res.key_tapped  = rda_r.down && (age_a == 6'd0);
          res.key_repeat  = rda_r.down && ((age_a == 6'd0) || (age_a >= thr_r));
          res.key_control = |(rda_r.mods & kst_pkg::MOD_CONTROL);
          res.key_shift   = |(rda_r.mods & kst_pkg::MOD_SHIFT);
          res.key_alt     = |(rda_r.mods & kst_pkg::MOD_ALT);
        end
      end
      kst_pkg::ACT_QUERY_HOT: begin
        if (func_ok(item_r.function_index)) begin
          res.hotkey_down   = m0_down || m1_down;
          res.hotkey_tapped = m0_tap || m1_tap;
        end
      end
      default: res = '0;
    endcase
  end

  // frame counter and scrub pointer advance on each tick
  always_comb begin
    tick_nxt  = tick_r;
    scrub_nxt = scrub_r;
    if (cmd.finish && item_r.action == kst_pkg::ACT_FRAME_TICK) begin
      tick_nxt  = tick_r + TW'(1);
      scrub_nxt = (scrub_r == KW'(NUM_KEYS - 1)) ? '0 : scrub_r + KW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= kst_pkg::REPEAT_RESET;
      tick_r  <= '0;
      scrub_r <= '0;
      clr_r   <= '0;
    end else begin
      if (cfg_wen) begin
        thr_r <= cfg_wdata;
      end
      tick_r  <= tick_nxt;
      scrub_r <= scrub_nxt;
      if (cmd.clear && !status.clear_last) begin
        clr_r <= clr_r + CW'(1);
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (cmd.rd_item) begin
      item_r <= in_item;
    end
    if (cmd.finish) begin
      result_r <= res;
    end
  end

endmodule
